FILE: rtl/core/omt_pkg.sv
// Shared constants, item types and control structs for the ordered multimap table.
package omt_pkg;

    // Table geometry.
    localparam int DEPTH      = 16;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;

    // Widths of the item fields.
    localparam int KEY_FIELD_W   = 32;
    localparam int VALUE_FIELD_W = 32;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int REMOVED_W     = 5;

    // Stored widths: a key or value never keeps more bits than its field carries.
    localparam int KW = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
    localparam int VW = (VALUE_BITS < VALUE_FIELD_W) ? VALUE_BITS : VALUE_FIELD_W;

    // Table address and entry count widths.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Largest count that the removed_count field can show.
    localparam int REMOVED_MAX = (1 << REMOVED_W) - 1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

    // Input item.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [KEY_FIELD_W-1:0]   key_in;
        logic [VALUE_FIELD_W-1:0] value_in;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [KEY_FIELD_W-1:0]   key_out;
        logic [VALUE_FIELD_W-1:0] value_out;
        logic [STATUS_W-1:0]      status;
        logic [REMOVED_W-1:0]     removed_count;
        logic                     last;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic step;
        logic finish;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic need_push;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/ordered_multimap_table_core.sv
// Top level of the ordered multimap table: controller and datapath.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------
//  in      | input     | in_valid / in_stall   | in_item_t
//  out     | output    | out_valid / out_stall | out_item_t
//
// Remove, find and dump scan the N live entries one per cycle through the single
// memory read port, while the out channel does not stall; an add does not scan. An
// item is taken only while the controller is idle; the result register lets the
// next item enter while the last result still waits. Reset empties the table at
// once; no clearing pass is needed.
module ordered_multimap_table_core
    import omt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    // Sequencing.
    omt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Storage and result path.
    omt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

FILE: rtl/core/omt_ctrl.sv
// Controller state machine that sequences add, remove, find and dump items.
module omt_ctrl
    import omt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Only an idle controller takes a new item.
    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // An add or an empty table ends the scan at once.
                if (status.scan_done)
                begin
                    state_next = S_FINISH;
                end
                else if (!status.need_push || status.out_free)
                begin
                    cmd.step = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/omt_datapath.sv
// Datapath: pair memory, scan and compaction pointers, pending entry and result register.
module omt_datapath
    import omt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   in_item,
    input  ctl_cmd_t   cmd,
    output dp_status_t status,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);

    // Pair memory.
    logic [KW-1:0] key_mem   [DEPTH];
    logic [VW-1:0] value_mem [DEPTH];

    // Item registers.
    logic [OP_W-1:0] op_reg;
    logic [KW-1:0]   key_reg;
    logic            full_reg;

    // Scan and compaction state.
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] wr_reg;
    logic [KW-1:0] rd_key_reg;
    logic [VW-1:0] rd_value_reg;

    // Entry held back until it is known whether it is the final one.
    logic          pend_valid_reg;
    logic [KW-1:0] pend_key_reg;
    logic [VW-1:0] pend_value_reg;

    // Result register.
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      out_load;

    logic [CW-1:0] idx_inc;
    logic [AW-1:0] rd_addr;
    logic          is_scan_op;
    logic          hit;
    logic          add_ok;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [KW-1:0] mem_wkey;
    logic [VW-1:0] mem_wvalue;
    logic [CW-1:0] removed;

    // Match logic on the entry just read.
    assign is_scan_op = (op_reg == OP_FIND) || (op_reg == OP_DUMP);
    assign hit        = (op_reg == OP_DUMP) || (rd_key_reg == key_reg);

    // Status to the controller.
    assign status.scan_done = (op_reg == OP_ADD) || (idx_reg == count_reg);
    assign status.need_push = is_scan_op && hit && pend_valid_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    // Read address runs ahead of the scan index, so the registered read data holds the entry at the index.
    assign idx_inc = idx_reg + CW'(1);
    always_comb
    begin
        if (cmd.accept)
        begin
            rd_addr = '0;
        end
        else if (cmd.step)
        begin
            rd_addr = idx_inc[AW-1:0];
        end
        else
        begin
            rd_addr = idx_reg[AW-1:0];
        end
    end

    // Memory write port: appends on add, compaction on remove.
    assign add_ok = (in_item.op == OP_ADD) && (count_reg < CW'(DEPTH));
    always_comb
    begin
        mem_we     = 1'b0;
        mem_wa     = count_reg[AW-1:0];
        mem_wkey   = in_item.key_in[KW-1:0];
        mem_wvalue = in_item.value_in[VW-1:0];
        if (cmd.accept)
        begin
            mem_we = add_ok;
        end
        else if (cmd.step && (op_reg == OP_REMOVE) && !hit)
        begin
            mem_we     = 1'b1;
            mem_wa     = wr_reg[AW-1:0];
            mem_wkey   = rd_key_reg;
            mem_wvalue = rd_value_reg;
        end
    end

    // Pair memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[mem_wa]   <= mem_wkey;
            value_mem[mem_wa] <= mem_wvalue;
        end
        rd_key_reg   <= key_mem[rd_addr];
        rd_value_reg <= value_mem[rd_addr];
    end

    // Item registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= in_item.op;
            key_reg  <= in_item.key_in[KW-1:0];
            full_reg <= (count_reg >= CW'(DEPTH));
        end
    end

    // Pending entry payload.
    always_ff @(posedge clk)
    begin
        if (cmd.step && is_scan_op && hit)
        begin
            pend_key_reg   <= rd_key_reg;
            pend_value_reg <= rd_value_reg;
        end
    end

    // Entry count, scan pointers and pending flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            idx_reg        <= '0;
            wr_reg         <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                idx_reg        <= '0;
                wr_reg         <= '0;
                pend_valid_reg <= 1'b0;
                if (add_ok)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            else if (cmd.step)
            begin
                idx_reg <= idx_inc;
                if ((op_reg == OP_REMOVE) && !hit)
                begin
                    wr_reg <= wr_reg + CW'(1);
                end
                if (is_scan_op && hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            else if (cmd.finish && (op_reg == OP_REMOVE))
            begin
                count_reg <= wr_reg;
            end
        end
    end

    // Next result: an earlier match during the scan, or the closing result.
    assign removed = count_reg - wr_reg;
    always_comb
    begin
        out_item_next = '0;
        out_load      = 1'b0;
        if (cmd.step && status.need_push)
        begin
            out_load                = 1'b1;
            out_item_next.key_out   = KEY_FIELD_W'(pend_key_reg);
            out_item_next.value_out = VALUE_FIELD_W'(pend_value_reg);
            out_item_next.status    = ST_OK;
        end
        else if (cmd.finish)
        begin
            out_load           = 1'b1;
            out_item_next.last = 1'b1;
            case (op_reg)
                OP_ADD:
                begin
                    out_item_next.status = full_reg ? ST_FULL : ST_OK;
                end
                OP_REMOVE:
                begin
                    out_item_next.status = ST_OK;
                    if (32'(removed) > 32'(REMOVED_MAX))
                    begin
                        out_item_next.removed_count = REMOVED_W'(REMOVED_MAX);
                    end
                    else
                    begin
                        out_item_next.removed_count = REMOVED_W'(removed);
                    end
                end
                default:
                begin
                    if (pend_valid_reg)
                    begin
                        out_item_next.key_out   = KEY_FIELD_W'(pend_key_reg);
                        out_item_next.value_out = VALUE_FIELD_W'(pend_value_reg);
                        out_item_next.status    = ST_OK;
                    end
                    else
                    begin
                        out_item_next.status = ST_NONE;
                    end
                end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

FILE: tb/ordered_multimap_table_core_tb.sv
// Testbench for the ordered multimap table core, with a self-checking result scoreboard.
`timescale 1ns / 1ps

module ordered_multimap_table_core_tb;
    import omt_pkg::*;

    // Shadow copy of the table that predicts every result item of each accepted item.
    class multimap_checker;
        logic [KEY_FIELD_W-1:0]   keys [DEPTH];
        logic [VALUE_FIELD_W-1:0] values [DEPTH];
        int unsigned              live;
        out_item_t                pending_results[$];
        int unsigned              errors;

        function new();
            live   = 0;
            errors = 0;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // Append one predicted result item at the tail of the queue.
        function void queue_result(out_item_t r);
            pending_results = {pending_results, r};
        endfunction

        function out_item_t make_result(logic [KEY_FIELD_W-1:0] k,
                                        logic [VALUE_FIELD_W-1:0] v,
                                        logic [STATUS_W-1:0] st,
                                        logic [REMOVED_W-1:0] removed,
                                        logic is_last);
            out_item_t r;
            r.key_out       = k;
            r.value_out     = v;
            r.status        = st;
            r.removed_count = removed;
            r.last          = is_last;
            return r;
        endfunction

        // Apply one accepted item to the shadow table and queue what it must produce.
        function void apply_op(in_item_t it);
            logic [KEY_FIELD_W-1:0]   k;
            logic [VALUE_FIELD_W-1:0] v;
            int unsigned              kept;
            int unsigned              removed;
            int unsigned              hits;
            k    = it.key_in & KEY_FIELD_W'((64'd1 << KW) - 64'd1);
            v    = it.value_in & VALUE_FIELD_W'((64'd1 << VW) - 64'd1);
            hits = 0;
            case (it.op)
                OP_ADD:
                begin
                    if (live >= DEPTH)
                    begin
                        queue_result(make_result('0, '0, ST_FULL, '0, 1'b1));
                    end
                    else
                    begin
                        keys[live]   = k;
                        values[live] = v;
                        live++;
                        queue_result(make_result('0, '0, ST_OK, '0, 1'b1));
                    end
                end
                OP_REMOVE:
                begin
                    // Compact the survivors toward the head, keeping their order.
                    kept = 0;
                    for (int i = 0; i < live; i++)
                    begin
                        if (keys[i] != k)
                        begin
                            keys[kept]   = keys[i];
                            values[kept] = values[i];
                            kept++;
                        end
                    end
                    removed = live - kept;
                    live    = kept;
                    if (removed > REMOVED_MAX)
                    begin
                        removed = REMOVED_MAX;
                    end
                    queue_result(make_result('0, '0, ST_OK, REMOVED_W'(removed), 1'b1));
                end
                default:
                begin
                    // Find reports matching entries; dump reports all of them.
                    for (int i = 0; i < live; i++)
                    begin
                        if (it.op == OP_DUMP || keys[i] == k)
                        begin
                            queue_result(make_result(keys[i], values[i], ST_OK, '0, 1'b0));
                            hits++;
                        end
                    end
                    if (hits == 0)
                    begin
                        queue_result(make_result('0, '0, ST_NONE, '0, 1'b1));
                    end
                    else
                    begin
                        pending_results[pending_results.size() - 1].last = 1'b1;
                    end
                end
            endcase
        endfunction

        function void flag(string why, out_item_t want, out_item_t got);
            errors++;
            if (errors <= 10)
            begin
                $display("%0t mismatch, %s: expected key %h value %h status %0d removed %0d last %0d",
                         $time, why, want.key_out, want.value_out, want.status,
                         want.removed_count, want.last);
                $display("    got key %h value %h status %0d removed %0d last %0d",
                         got.key_out, got.value_out, got.status, got.removed_count,
                         got.last);
            end
        endfunction

        // Compare one accepted result item with the oldest prediction.
        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_results.size() == 0)
            begin
                flag("result with nothing outstanding", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.key_out !== want.key_out || got.value_out !== want.value_out ||
                got.status !== want.status || got.removed_count !== want.removed_count ||
                got.last !== want.last)
            begin
                flag("wrong field", want, got);
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;

    multimap_checker        sb = new();
    logic [KEY_FIELD_W-1:0] key_pool[$];
    bit                     no_idle = 1'b0;
    bit                     holding = 1'b0;
    event                   hold_start;

    ordered_multimap_table_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic in_item_t make_item(logic [OP_W-1:0] op,
                                           logic [KEY_FIELD_W-1:0] k,
                                           logic [VALUE_FIELD_W-1:0] v);
        in_item_t it;
        it.op       = op;
        it.key_in   = k;
        it.value_in = v;
        return it;
    endfunction

    // Random item whose key mostly comes from the current pool, so that matches happen.
    function automatic in_item_t random_item(int add_pct);
        logic [OP_W-1:0]        op;
        logic [KEY_FIELD_W-1:0] k;
        int                     s;
        if ($urandom_range(0, 99) < add_pct)
        begin
            op = OP_ADD;
        end
        else
        begin
            s = $urandom_range(0, 9);
            op = (s < 3) ? OP_REMOVE : (s < 7) ? OP_FIND : OP_DUMP;
        end
        if ($urandom_range(0, 9) < 8)
        begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        else
        begin
            k = $urandom();
        end
        return make_item(op, k, $urandom());
    endfunction

    // Offer one item after an optional gap and wait until the block takes it.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = no_idle ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        sb.apply_op(it);
    endtask

    // Receiver: checks each accepted result item and stalls at random.
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_result(out_item);
            end
            if (holding)
            begin
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = idle_len();
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Long hold-off of the receiver, counted here so that the sender keeps offering items.
    initial
    begin
        forever
        begin
            @(hold_start);
            @(posedge clk);
            holding <= 1'b1;
            repeat (300) @(posedge clk);
            holding <= 1'b0;
        end
    end

    // Stimulus: directed corner items, then random episodes over small key pools.
    initial
    begin
        in_item_t directed[$];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: dump and find report no entry, and remove reports zero removed.
        directed = {directed, make_item(OP_DUMP, '0, '0)};
        directed = {directed, make_item(OP_FIND, '1, '1)};
        directed = {directed, make_item(OP_REMOVE, '0, '0)};
        // Extreme keys and values, then fill to capacity with a repeated key.
        directed = {directed, make_item(OP_ADD, '0, '1)};
        directed = {directed, make_item(OP_ADD, '1, '0)};
        for (int i = 0; i < DEPTH - 2; i++)
        begin
            directed = {directed, make_item(OP_ADD, '0, $urandom())};
        end
        directed = {directed, make_item(OP_FIND, '0, '0)};
        directed = {directed, make_item(OP_FIND, 32'h1234_5678, '0)};
        directed = {directed, make_item(OP_ADD, 32'h5555_AAAA, 32'hAAAA_5555)};
        directed = {directed, make_item(OP_DUMP, '0, '0)};
        directed = {directed, make_item(OP_REMOVE, '0, '0)};
        directed = {directed, make_item(OP_REMOVE, '1, '0)};
        foreach (directed[i])
        begin
            send_item(directed[i]);
        end

        // Random episodes; even ones lean on adds to reach a full table.
        for (int ep = 0; ep < 6; ep++)
        begin
            key_pool.delete();
            repeat ((ep == 0) ? 1 : $urandom_range(1, 4))
            begin
                key_pool = {key_pool, KEY_FIELD_W'($urandom())};
            end
            no_idle = (ep == 2 || ep == 4);
            if (ep == 4)
            begin
                -> hold_start;
            end
            repeat (16)
            begin
                send_item(random_item((ep % 2 == 0) ? 75 : 40));
            end
        end
        in_valid <= 1'b0;

        // Drain the remaining results, then keep watching for strays before the verdict.
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #(5_000_000);
        $display("== FAIL ==");
        $finish;
    end

endmodule
